>>> rtl/sp2g_pkg.sv
// Shared types, constants and the sine table builder for the scan polar-to-grid pixel unit.
// Used by sp2g_ctrl, sp2g_datapath and scan_polar_to_grid_pixel_unit. No dependencies.
package sp2g_pkg;

  localparam int IMAGE_SIZE_DEF = 500;
  localparam int TRIG_DEPTH_DEF = 1024;

  localparam int PIX_W     = 12;
  localparam int ANGLE_W   = 16;
  localparam int RANGE_W   = 32;
  localparam int TRIG_W    = 16;
  localparam int MAG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL  = 2'd3;

  localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'd32768;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd182;
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = 32'd0;
  localparam logic [RANGE_W-1:0] RANGE_CEIL_RST  = 32'd229376;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  typedef struct packed {
    logic load_item;
    logic rom_read;
    logic mul_a;
    logic mul_b;
    logic div_load;
    logic div_step;
    logic store_coord;
    logic sel_sin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  // Q1.15 sine of a 32-bit turn phase by a nine-term Taylor series on the folded quadrant
  function automatic logic signed [TRIG_W-1:0] trig_from_phase(input logic [63:0] phase);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] mag;
    longint      sum;
    quad = phase[31:30];
    r    = {34'd0, phase[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x   = (r * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    t   = x;
    sum = longint'(x);
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + longint'(t);
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + longint'(t);
    t   = ((t * x2) >> 30) / 64'd110;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 64'd156;
    sum = sum + longint'(t);
    t   = ((t * x2) >> 30) / 64'd210;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 64'd272;
    sum = sum + longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -$signed(mag[TRIG_W-1:0]) : $signed(mag[TRIG_W-1:0]);
  endfunction

endpackage

>>> rtl/sp2g_ctrl.sv
// Sequencing state machine for the scan polar-to-grid pixel unit.
// Depends on sp2g_pkg for the command and status structs.
module sp2g_ctrl import sp2g_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_MULA = 3'd2;
  localparam logic [2:0] S_MULB = 3'd3;
  localparam logic [2:0] S_DLD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       sel;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.sel_sin = sel;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.rom_read = 1'b1;
        state_next   = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = S_DLD;
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.store_coord = 1'b1;
        state_next      = sel ? S_OUT : S_ADDR;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_item) begin
        sel <= 1'b0;
      end else if (cmd.store_coord) begin
        sel <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sp2g_datapath.sv
// Datapath: configuration registers, sample index, sine ROM, multipliers, radix-4 divider
// and output register. Depends on sp2g_pkg.
module sp2g_datapath import sp2g_pkg::*; #(
  parameter int IMAGE_SIZE       = IMAGE_SIZE_DEF,
  parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [RANGE_W-1:0]   range_sample,
  input  logic                 scan_start,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic [PIX_W-1:0]     pixel_x,
  output logic [PIX_W-1:0]     pixel_y,
  output logic                 hit
);

  localparam int IMG_W   = $clog2(IMAGE_SIZE + 1);
  localparam int PROD1_W = RANGE_W + MAG_W;
  localparam int PROD2_W = PROD1_W + IMG_W;
  localparam int Q_W     = 2 * ((MAG_W + IMG_W + 1) / 2);
  localparam int DIV_CYC = Q_W / 2;
  localparam int CNT_W   = $clog2(DIV_CYC);
  localparam int K_W     = $clog2(TRIG_TABLE_DEPTH);
  localparam int KP_W    = ANGLE_W + 17;
  localparam int C_W     = Q_W + 2;
  localparam int HALF    = IMAGE_SIZE / 2;

  logic [ANGLE_W-1:0]       start_angle;
  logic [ANGLE_W-1:0]       angle_step;
  logic [RANGE_W-1:0]       min_range;
  logic [RANGE_W-1:0]       range_ceil;
  logic [ANGLE_W-1:0]       sample_index;
  logic [RANGE_W-1:0]       range_q;
  logic [ANGLE_W-1:0]       angle;
  logic                     in_lim;
  logic signed [TRIG_W-1:0] trig_q;
  logic                     neg;
  logic [PROD1_W-1:0]       prod1;
  logic [PROD2_W-1:0]       prod2;
  logic [RANGE_W-1:0]       rem;
  logic [Q_W-1:0]           dvd;
  logic [CNT_W-1:0]         dcnt;
  logic [PIX_W-1:0]         x_q;
  logic                     x_in;
  logic [PIX_W-1:0]         y_q;
  logic                     y_in;

  logic signed [TRIG_W-1:0] trig_rom [TRIG_TABLE_DEPTH];

  logic [ANGLE_W-1:0]       idx;
  logic [2*ANGLE_W-1:0]     idx_prod;
  logic [ANGLE_W-1:0]       rd_angle;
  logic [KP_W-1:0]          kprod;
  logic [K_W-1:0]           k;
  logic [MAG_W-1:0]         mag;
  logic [RANGE_W:0]         r1;
  logic [RANGE_W:0]         r2;
  logic [RANGE_W-1:0]       rem1;
  logic                     q1;
  logic                     q2;
  logic [RANGE_W-1:0]       rem_next;
  logic [C_W-1:0]           coord;
  logic                     in_image;
  logic                     hit_next;

  for (genvar g = 0; g < TRIG_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] PH = (64'(g) << 32) / 64'(TRIG_TABLE_DEPTH);
    assign trig_rom[g] = trig_from_phase(PH);
  end

  assign idx      = scan_start ? '0 : sample_index;
  assign idx_prod = idx * angle_step;
  assign rd_angle = cmd.sel_sin ? angle : angle + QUARTER_TURN;
  assign kprod    = KP_W'(rd_angle) * KP_W'(TRIG_TABLE_DEPTH);
  assign k        = kprod[ANGLE_W +: K_W];
  assign mag      = trig_q[TRIG_W-1] ? MAG_W'(-trig_q) : trig_q[MAG_W-1:0];

  // two restoring steps per cycle
  always_comb begin
    r1 = {rem, dvd[Q_W-1]};
    q1 = (r1 >= {1'b0, range_ceil});
    rem1 = q1 ? RANGE_W'(r1 - {1'b0, range_ceil}) : r1[RANGE_W-1:0];
    r2 = {rem1, dvd[Q_W-2]};
    q2 = (r2 >= {1'b0, range_ceil});
    rem_next = q2 ? RANGE_W'(r2 - {1'b0, range_ceil}) : r2[RANGE_W-1:0];
  end

  assign sts.div_last = (dcnt == CNT_W'(DIV_CYC - 1));

  assign coord    = neg ? C_W'(HALF) - {2'b00, dvd} : C_W'(HALF) + {2'b00, dvd};
  assign in_image = !coord[C_W-1] && (coord < C_W'(IMAGE_SIZE));
  assign hit_next = in_lim && x_in && y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle  <= START_ANGLE_RST;
      angle_step   <= ANGLE_STEP_RST;
      min_range    <= MIN_RANGE_RST;
      range_ceil   <= RANGE_CEIL_RST;
      sample_index <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_ANGLE: start_angle <= cfg_data[ANGLE_W-1:0];
          REG_ANGLE_STEP:  angle_step  <= cfg_data[ANGLE_W-1:0];
          REG_MIN_RANGE:   min_range   <= cfg_data;
          REG_RANGE_CEIL:  range_ceil  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_item) begin
        sample_index <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      range_q <= range_sample;
      angle   <= start_angle + idx_prod[ANGLE_W-1:0];
      in_lim  <= (range_sample > min_range) && (range_sample < range_ceil);
    end
    if (cmd.rom_read) begin
      trig_q <= trig_rom[k];
    end
    if (cmd.mul_a) begin
      prod1 <= PROD1_W'(range_q) * PROD1_W'(mag);
      neg   <= trig_q[TRIG_W-1];
    end
    if (cmd.mul_b) begin
      prod2 <= PROD2_W'(prod1) * PROD2_W'(IMAGE_SIZE);
    end
    if (cmd.div_load) begin
      rem  <= RANGE_W'(prod2 >> (16 + Q_W));
      dvd  <= prod2[16 +: Q_W];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      dvd  <= {dvd[Q_W-3:0], q1, q2};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.store_coord) begin
      if (cmd.sel_sin) begin
        y_q  <= coord[PIX_W-1:0];
        y_in <= in_image;
      end else begin
        x_q  <= coord[PIX_W-1:0];
        x_in <= in_image;
      end
    end
    if (cmd.load_out) begin
      pixel_x <= hit_next ? x_q : '0;
      pixel_y <= hit_next ? y_q : '0;
      hit     <= hit_next;
    end
  end

endmodule

>>> rtl/scan_polar_to_grid_pixel_unit.sv
// Per axis one ROM read, two multiplies and a radix-4 divide, x then y through the shared
// divider. The input stalls from acceptance until the result enters the output register,
// so only one item is in work at a time.
// The result register frees the input side while a finished result waits.
// Reset (rst, synchronous): configuration to defaults, sample index to zero, output empty.
module scan_polar_to_grid_pixel_unit import sp2g_pkg::*; #(
  parameter int IMAGE_SIZE       = IMAGE_SIZE_DEF,
  parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RANGE_W-1:0]   range_sample,
  input  logic                 scan_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     pixel_x,
  output logic [PIX_W-1:0]     pixel_y,
  output logic                 hit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sp2g_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sp2g_datapath #(
    .IMAGE_SIZE       (IMAGE_SIZE),
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .range_sample (range_sample),
    .scan_start   (scan_start),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .hit          (hit)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transaction");

  a_hit_in_image: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (pixel_x < PIX_W'(IMAGE_SIZE)) && (pixel_y < PIX_W'(IMAGE_SIZE)))
    else $error("hit pixel outside image");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (pixel_x == '0) && (pixel_y == '0))
    else $error("miss carries non-zero pixel");

endmodule
